### sv/tda_pkg.sv
package tda_pkg;

  // Fixed-point format and table geometry.
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned EXP_TABLE_BITS = 8;
  localparam int unsigned SAMPLE_WIDTH   = 32;
  localparam int unsigned NEG_LOG2_FRAC  = 16;
  localparam int unsigned TABLE_SIZE     = 1 << EXP_TABLE_BITS;
  localparam int unsigned COEF_W         = FRAC_BITS + 1;

  // Field and state widths.
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned SAMPLE_IN_W = 40;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned WS_W       = 64;
  localparam int unsigned WT_W       = 48;
  localparam int unsigned NL_W       = 21;
  localparam int unsigned INTERVAL_W = 32;
  localparam int unsigned MUL_A_W    = 32;
  localparam int unsigned MUL_B_W    = NL_W;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned HI_W       = 38;
  localparam int unsigned QUO_W      = 32;
  localparam int unsigned REM_W      = WT_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // A coefficient whose integer shift reaches this value is zero.
  localparam int unsigned COEF_SHIFT_LIMIT = 32;
  // Coefficients at or below this value are a decay of 0.001 or stronger.
  localparam int unsigned SMALL_COEF_MAX   = (1 << FRAC_BITS) / 1000;

  localparam logic [VALUE_W-1:0] SAMPLE_MAX = VALUE_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);
  localparam logic [WT_W-1:0]    WT_ONE     = WT_W'(64'd1 << FRAC_BITS);
  localparam logic [COEF_W-1:0]  COEF_ONE   = COEF_W'(64'd1 << FRAC_BITS);

  localparam logic [NL_W-1:0]       NL_RESET       = NL_W'(65536);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);

  localparam logic [63:0] ONE_Q63      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LN2_Q63      = 64'h58B9_0BFB_E8E7_BCD5;
  localparam int unsigned TAYLOR_TERMS = 30;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } tda_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAST_ONLY = 2'd0,
    CFG_NEG_LOG2  = 2'd1,
    CFG_INTERVAL  = 2'd2
  } tda_cfg_idx_e;

  typedef struct packed {
    logic                   command;
    logic [TIME_W-1:0]      now_ms;
    logic [SAMPLE_IN_W-1:0] sample_ms;
  } tda_sample_t;

  typedef struct packed {
    logic [VALUE_W-1:0] average_ms;
    logic [VALUE_W-1:0] last_sample_ms;
  } tda_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } tda_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM_HI,
    ST_EXP_CHK,
    ST_DIV_EXP,
    ST_SCALE_0,
    ST_SCALE_1,
    ST_SCALE_2,
    ST_SCALE_3,
    ST_SCALE_4,
    ST_UPDATE,
    ST_AVG,
    ST_DIV_AVG,
    ST_RESULT
  } tda_state_e;

  typedef enum logic [2:0] {
    MUL_ELAPSED_LO,
    MUL_ELAPSED_HI,
    MUL_WS_LO,
    MUL_WS_HI,
    MUL_WT_LO,
    MUL_WT_HI
  } tda_mul_sel_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_WS_LO,
    ACC_WS_HI,
    ACC_WT_LO,
    ACC_WT_HI
  } tda_acc_e;

  typedef enum logic {
    DIV_EXP,
    DIV_AVG
  } tda_div_sel_e;

  typedef struct packed {
    logic         in_ready;
    tda_mul_sel_e mul_sel;
    logic         load_pb;
    logic         load_hi;
    logic         coef_zero;
    logic         div_start;
    tda_div_sel_e div_sel;
    logic         load_coef;
    tda_acc_e     acc_op;
    logic         update_sums;
    logic         avg_direct;
    logic         avg_from_div;
    logic         out_load;
  } tda_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic in_restart;
    logic exp_big;
    logic div_done;
    logic avg_direct;
    logic out_free;
  } tda_status_t;

  typedef logic [TABLE_SIZE-1:0][COEF_W-1:0] coef_rom_t;

  // floor(a * b / 2^63)
  function automatic logic [63:0] mul_q63(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[126:63];
  endfunction

  // Entry k is round(2^FRAC_BITS * 2^(-k/TABLE_SIZE)), from a Taylor series in Q63.
  function automatic coef_rom_t build_coef_rom();
    coef_rom_t   rom;
    logic [63:0] kk;
    logic [63:0] t;
    logic [63:0] res;
    logic [63:0] term;
    for (int k = 0; k < int'(TABLE_SIZE); k++) begin
      kk   = 64'(k);
      t    = (LN2_Q63 >> EXP_TABLE_BITS) * kk
           + (((LN2_Q63 & 64'(TABLE_SIZE - 1)) * kk) >> EXP_TABLE_BITS);
      res  = ONE_Q63;
      term = ONE_Q63;
      for (int n = 1; n <= int'(TAYLOR_TERMS); n++) begin
        term = mul_q63(term, t) / 64'(n);
        if ((n % 2) == 1) begin
          res = res - term;
        end else begin
          res = res + term;
        end
      end
      rom[k] = COEF_W'((res + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS));
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_coef_rom();

endpackage

### sv/tda_chan_if.sv
interface tda_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/time_decayed_average_core.sv
// Time-decayed moving average of millisecond samples.
//
// Three channels, each a valid/ready transaction: sample_ch carries a command
// (add a sample or clear), a 48-bit timestamp and a 40-bit sample; result_ch
// returns the decayed average and the last saturated sample, one result per
// input transaction; cfg_ch writes the registers (0 last-only mode, 1 minus
// log2 of the decay factor in Q5.16, 2 decay interval in ms) and is always
// ready. Write configuration only while the block is idle.
//
// The block handles one item at a time. An added sample's result goes through these steps
// after acceptance: the exponent on the shared 32x21 multiplier, a division in the shared
// restoring divider, scaling of the sums, their update, a division in the divider for the
// average and the output load. An overflowing exponent skips the first division and the
// scaling; an empty or saturated average skips the second. A clear or a last-only sample
// goes straight to the average, which it takes without a division. sample_ch is ready only
// while idle, so the next transaction is taken no earlier than the cycle after a result loads.
//
// Reset loads the register defaults and empties the sums and the timing. The
// finished result sits in an output register; the next sample can be taken
// while it waits, and a following result stalls in place until result_ch drains.
module time_decayed_average_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  tda_chan_if.sink   sample_ch,
  tda_chan_if.source result_ch,
  tda_chan_if.sink   cfg_ch
);
  import tda_pkg::*;

  // Configuration registers.
  logic                  last_only_q;
  logic [NL_W-1:0]       neg_log2_q;
  logic [INTERVAL_W-1:0] interval_q;
  logic [INTERVAL_W-1:0] interval_eff;

  // Architectural state.
  logic [TIME_W-1:0]  last_time_q,  last_time_d;
  logic [VALUE_W-1:0] last_value_q, last_value_d;
  logic [WS_W-1:0]    ws_q,         ws_d;
  logic [WT_W-1:0]    wt_q,         wt_d;

  // Working registers of the current transaction.
  logic [TIME_W-1:0]  elapsed_q;
  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W-1:0]  pb_q;
  logic [HI_W-1:0]    hi_q;
  logic [COEF_W-1:0]  c_q;
  logic [WS_W-1:0]    acc_ws_q;
  logic [WT_W-1:0]    acc_wt_q;
  logic [VALUE_W-1:0] avg_q;
  tda_result_t        out_q;
  logic               out_valid_q;

  tda_ctrl_t   ctrl;
  tda_status_t status;

  logic               in_fire;
  logic               cfg_fire;
  tda_sample_t        in_item;
  tda_cfg_t           cfg_item;
  logic [VALUE_W-1:0] v_sat;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  logic [QUO_W-1:0]   div_rem_init;
  logic [QUO_W-1:0]   div_low;
  logic [REM_W-1:0]   div_divisor;
  logic [QUO_W-1:0]   div_quo;
  logic               div_done;

  logic [QUO_W-NEG_LOG2_FRAC-1:0] coef_ip;
  logic [EXP_TABLE_BITS-1:0]      coef_idx;
  logic [COEF_W-1:0]              coef_val;

  logic [WS_W-1:0] vf;
  logic [WS_W:0]   sum_ws;
  logic [WT_W:0]   sum_wt;
  logic            restart;
  logic            avg_empty;
  logic            avg_sat;

  assign in_item  = sample_ch.payload;
  assign cfg_item = cfg_ch.payload;

  assign sample_ch.ready = ctrl.in_ready;
  assign cfg_ch.ready    = 1'b1;
  assign in_fire         = sample_ch.valid & ctrl.in_ready;
  assign cfg_fire        = cfg_ch.valid;

  assign result_ch.valid   = out_valid_q;
  assign result_ch.payload = out_q;

  // A zero interval behaves as one millisecond.
  assign interval_eff = (interval_q == '0) ? INTERVAL_W'(1) : interval_q;

  // Samples wider than the sample range saturate.
  assign v_sat = (|in_item.sample_ms[SAMPLE_IN_W-1:SAMPLE_WIDTH])
               ? SAMPLE_MAX : in_item.sample_ms[VALUE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_only_q <= 1'b0;
      neg_log2_q  <= NL_RESET;
      interval_q  <= INTERVAL_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_item.reg_index)
        CFG_LAST_ONLY: last_only_q <= cfg_item.wdata[0];
        CFG_NEG_LOG2:  neg_log2_q  <= cfg_item.wdata[NL_W-1:0];
        CFG_INTERVAL:  interval_q  <= cfg_item.wdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // The sequencer and the shared divider.
  tda_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  always_comb begin
    if (ctrl.div_sel == DIV_AVG) begin
      div_rem_init = ws_q[WS_W-1:QUO_W];
      div_low      = ws_q[QUO_W-1:0];
      div_divisor  = wt_q;
    end else begin
      div_rem_init = hi_q[QUO_W-1:0];
      div_low      = pb_q[QUO_W-1:0];
      div_divisor  = REM_W'(interval_eff);
    end
  end

  tda_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .rem_init_i (div_rem_init),
    .low_i      (div_low),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // Shared multiplier: operands follow the sequencer, the product is registered.
  always_comb begin
    mul_b = MUL_B_W'(c_q);
    unique case (ctrl.mul_sel)
      MUL_ELAPSED_LO: begin
        mul_a = elapsed_q[MUL_A_W-1:0];
        mul_b = neg_log2_q;
      end
      MUL_ELAPSED_HI: begin
        mul_a = MUL_A_W'(elapsed_q[TIME_W-1:MUL_A_W]);
        mul_b = neg_log2_q;
      end
      MUL_WS_LO: mul_a = ws_q[MUL_A_W-1:0];
      MUL_WS_HI: mul_a = ws_q[WS_W-1:MUL_A_W];
      MUL_WT_LO: mul_a = wt_q[MUL_A_W-1:0];
      MUL_WT_HI: mul_a = MUL_A_W'(wt_q[WT_W-1:MUL_A_W]);
      default:   mul_a = '0;
    endcase
  end

  // The exponent e is the divider quotient in Q.16; its top bits shift the
  // table entry picked by the leading fraction bits.
  always_comb begin
    coef_ip  = div_quo[QUO_W-1:NEG_LOG2_FRAC];
    coef_idx = div_quo[NEG_LOG2_FRAC-1:NEG_LOG2_FRAC-EXP_TABLE_BITS];
    if (coef_ip >= (QUO_W-NEG_LOG2_FRAC)'(COEF_SHIFT_LIMIT)) begin
      coef_val = '0;
    end else begin
      coef_val = COEF_ROM[coef_idx] >> coef_ip[$clog2(COEF_SHIFT_LIMIT)-1:0];
    end
  end

  // Sum update: add the new sample with weight one unless the coefficient is
  // negligible or either sum would overflow, in which case the sums restart.
  always_comb begin
    vf      = WS_W'(last_value_q) << FRAC_BITS;
    sum_ws  = {1'b0, acc_ws_q} + {1'b0, vf};
    sum_wt  = {1'b0, acc_wt_q} + {1'b0, WT_ONE};
    restart = (c_q <= COEF_W'(SMALL_COEF_MAX)) | sum_ws[WS_W] | sum_wt[WT_W];
  end

  always_comb begin
    last_time_d  = last_time_q;
    last_value_d = last_value_q;
    ws_d         = ws_q;
    wt_d         = wt_q;
    if (in_fire) begin
      last_time_d = in_item.now_ms;
      if (in_item.command == CMD_CLEAR) begin
        last_value_d = '0;
        ws_d         = '0;
        wt_d         = '0;
      end else begin
        last_value_d = v_sat;
        if (last_only_q) begin
          ws_d = WS_W'(v_sat) << FRAC_BITS;
          wt_d = WT_ONE;
        end
      end
    end
    if (ctrl.update_sums) begin
      if (restart) begin
        ws_d = vf;
        wt_d = WT_ONE;
      end else begin
        ws_d = sum_ws[WS_W-1:0];
        wt_d = sum_wt[WT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q  <= '0;
      last_value_q <= '0;
      ws_q         <= '0;
      wt_q         <= '0;
    end else begin
      last_time_q  <= last_time_d;
      last_value_q <= last_value_d;
      ws_q         <= ws_d;
      wt_q         <= wt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
    if (in_fire) begin
      elapsed_q <= in_item.now_ms - last_time_q;
    end
    if (ctrl.load_pb) begin
      pb_q <= prod_q;
    end
    if (ctrl.load_hi) begin
      hi_q <= HI_W'(prod_q) + HI_W'(pb_q >> MUL_A_W);
    end
    if (ctrl.coef_zero) begin
      c_q <= '0;
    end else if (ctrl.load_coef) begin
      c_q <= coef_val;
    end
    unique case (ctrl.acc_op)
      ACC_WS_LO: acc_ws_q <= WS_W'(prod_q >> FRAC_BITS);
      ACC_WS_HI: acc_ws_q <= acc_ws_q + (WS_W'(prod_q) << (MUL_A_W - FRAC_BITS));
      ACC_WT_LO: acc_wt_q <= WT_W'(prod_q >> FRAC_BITS);
      ACC_WT_HI: acc_wt_q <= acc_wt_q + WT_W'(WS_W'(prod_q) << (MUL_A_W - FRAC_BITS));
      default: ;
    endcase
    if (ctrl.avg_direct) begin
      if (last_only_q) begin
        avg_q <= last_value_q;
      end else if (avg_empty) begin
        avg_q <= '0;
      end else begin
        avg_q <= SAMPLE_MAX;
      end
    end else if (ctrl.avg_from_div) begin
      avg_q <= div_quo;
    end
    if (ctrl.out_load) begin
      out_q.average_ms     <= avg_q;
      out_q.last_sample_ms <= last_value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The average saturates once the quotient would not fit in the sample range.
  assign avg_empty = (ws_q == '0) | (wt_q == '0);
  assign avg_sat   = WT_W'(ws_q[WS_W-1:QUO_W]) >= wt_q;

  always_comb begin
    status.in_valid   = sample_ch.valid;
    status.in_restart = (in_item.command == CMD_CLEAR) | last_only_q;
    status.exp_big    = hi_q >= HI_W'(interval_eff);
    status.div_done   = div_done;
    status.avg_direct = last_only_q | avg_empty | avg_sat;
    status.out_free   = ~out_valid_q | result_ch.ready;
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !sample_ch.ready)
    else $error("input taken again before the current transaction finished");

  a_weight_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.update_sums |=> (wt_q >= WT_ONE))
    else $error("weight sum below one after an update");

  a_sums_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wt_q == '0) |-> (ws_q == '0))
    else $error("weighted sum left without a weight");

  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_coef |=> (c_q <= COEF_ONE))
    else $error("decay coefficient above one");

endmodule

### sv/tda_div.sv
module tda_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tda_pkg::QUO_W-1:0]       rem_init_i,
  input  logic [tda_pkg::QUO_W-1:0]       low_i,
  input  logic [tda_pkg::REM_W-1:0]       divisor_i,
  output logic [tda_pkg::QUO_W-1:0]       quotient_o,
  output logic                            done_o
);
  import tda_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W);

  logic [REM_W-1:0] rem_q;
  logic [REM_W-1:0] div_q;
  logic [QUO_W-1:0] low_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [REM_W:0]   trial;
  logic             fits;
  logic [REM_W-1:0] rem_next;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial    = {rem_q, low_q[QUO_W-1]};
    fits     = trial >= {1'b0, div_q};
    rem_next = fits ? REM_W'(trial - {1'b0, div_q}) : trial[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= REM_W'(rem_init_i);
      low_q <= low_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_next;
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while a division is running");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < div_q))
    else $error("partial remainder not below the divisor");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (busy_q && !done_q))
    else $error("divider did not go busy after start");

endmodule

### sv/tda_ctrl.sv
module tda_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tda_pkg::tda_status_t status_i,
  output tda_pkg::tda_ctrl_t   ctrl_o
);
  import tda_pkg::*;

  tda_state_e state_q;
  tda_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid) begin
          state_d = status_i.in_restart ? ST_AVG : ST_MUL_LO;
        end
      end
      ST_MUL_LO:  state_d = ST_MUL_HI;
      ST_MUL_HI:  state_d = ST_SUM_HI;
      ST_SUM_HI:  state_d = ST_EXP_CHK;
      ST_EXP_CHK: state_d = status_i.exp_big ? ST_UPDATE : ST_DIV_EXP;
      ST_DIV_EXP: begin
        if (status_i.div_done) begin
          state_d = ST_SCALE_0;
        end
      end
      ST_SCALE_0: state_d = ST_SCALE_1;
      ST_SCALE_1: state_d = ST_SCALE_2;
      ST_SCALE_2: state_d = ST_SCALE_3;
      ST_SCALE_3: state_d = ST_SCALE_4;
      ST_SCALE_4: state_d = ST_UPDATE;
      ST_UPDATE:  state_d = ST_AVG;
      ST_AVG:     state_d = status_i.avg_direct ? ST_RESULT : ST_DIV_AVG;
      ST_DIV_AVG: begin
        if (status_i.div_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '{
      in_ready:     1'b0,
      mul_sel:      MUL_ELAPSED_LO,
      load_pb:      1'b0,
      load_hi:      1'b0,
      coef_zero:    1'b0,
      div_start:    1'b0,
      div_sel:      DIV_EXP,
      load_coef:    1'b0,
      acc_op:       ACC_NONE,
      update_sums:  1'b0,
      avg_direct:   1'b0,
      avg_from_div: 1'b0,
      out_load:     1'b0
    };
    unique case (state_q)
      ST_IDLE:    ctrl_o.in_ready = 1'b1;
      ST_MUL_LO:  ctrl_o.mul_sel = MUL_ELAPSED_LO;
      ST_MUL_HI: begin
        ctrl_o.mul_sel = MUL_ELAPSED_HI;
        ctrl_o.load_pb = 1'b1;
      end
      ST_SUM_HI:  ctrl_o.load_hi = 1'b1;
      ST_EXP_CHK: begin
        ctrl_o.div_sel = DIV_EXP;
        if (status_i.exp_big) begin
          ctrl_o.coef_zero = 1'b1;
        end else begin
          ctrl_o.div_start = 1'b1;
        end
      end
      ST_DIV_EXP: ctrl_o.load_coef = status_i.div_done;
      ST_SCALE_0: ctrl_o.mul_sel = MUL_WS_LO;
      ST_SCALE_1: begin
        ctrl_o.mul_sel = MUL_WS_HI;
        ctrl_o.acc_op  = ACC_WS_LO;
      end
      ST_SCALE_2: begin
        ctrl_o.mul_sel = MUL_WT_LO;
        ctrl_o.acc_op  = ACC_WS_HI;
      end
      ST_SCALE_3: begin
        ctrl_o.mul_sel = MUL_WT_HI;
        ctrl_o.acc_op  = ACC_WT_LO;
      end
      ST_SCALE_4: ctrl_o.acc_op = ACC_WT_HI;
      ST_UPDATE:  ctrl_o.update_sums = 1'b1;
      ST_AVG: begin
        ctrl_o.div_sel = DIV_AVG;
        if (status_i.avg_direct) begin
          ctrl_o.avg_direct = 1'b1;
        end else begin
          ctrl_o.div_start = 1'b1;
        end
      end
      ST_DIV_AVG: ctrl_o.avg_from_div = status_i.div_done;
      ST_RESULT:  ctrl_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

### tb/time_decayed_average_core_tb.sv
module time_decayed_average_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tda_pkg::*;

  // The run is stopped here in any case, well above what a correct run of
  // about 1250 transactions needs, sender gaps and receiver stalls included.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Cycles to wait after the last result, a little above one sample's latency.
  localparam int unsigned TAIL_CYCLES = 120;

  // Register index 3 has no register behind it, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Constants for the coefficient table: ln 2 in Q63 and the length of the series.
  localparam logic [63:0]  LN2_FIXED      = 64'h58B9_0BFB_E8E7_BCD5;
  localparam logic [63:0]  UNITY_Q63      = 64'h8000_0000_0000_0000;
  localparam int unsigned  SERIES_TERMS   = 30;
  localparam logic [WT_W-1:0] WEIGHT_UNIT = WT_W'(1) << FRAC_BITS;
  localparam logic [63:0]  WS_MAX         = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [WT_W-1:0] WT_MAX      = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  tda_chan_if #(.payload_t(tda_sample_t)) sample_ch ();
  tda_chan_if #(.payload_t(tda_result_t)) result_ch ();
  tda_chan_if #(.payload_t(tda_cfg_t))    cfg_ch ();

  time_decayed_average_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .cfg_ch    (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies, as the block should hold them after each write.
  logic                  cfg_last_only;
  logic [NL_W-1:0]       cfg_neg_log2;
  logic [INTERVAL_W-1:0] cfg_interval;

  // Averaging state of the prediction.
  logic [TIME_W-1:0]  avg_last_time;
  logic [VALUE_W-1:0] avg_last_value;
  logic [WS_W-1:0]    avg_weighted_sum;
  logic [WT_W-1:0]    avg_weight_sum;

  // round(2^FRAC_BITS * 2^(-k/TABLE_SIZE)) for every fractional exponent step k.
  logic [COEF_W-1:0] coef_table [TABLE_SIZE];

  // Results still owed by the block, oldest first.
  tda_result_t expected_results [$];
  tda_result_t next_expected;

  int unsigned error_count     = 0;
  int unsigned items_sent      = 0;
  int unsigned clears_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned cycle_count     = 0;

  // Traffic shaping. The sender works in bursts separated by gaps; the
  // receiver drops ready for runs of random length. Either can be switched
  // off to get stretches of back-to-back transactions.
  bit          tx_gaps_on   = 1'b1;
  bit          rx_stalls_on = 1'b1;
  int unsigned burst_left   = 0;
  int unsigned rx_hold      = 0;

  // Timestamp carried from one random transaction to the next.
  logic [TIME_W-1:0] stream_now = '0;

  // The table is built the same way the block's ROM is defined: a Taylor
  // series of exp(-k*ln2/TABLE_SIZE) in Q63, rounded to FRAC_BITS.
  initial begin : coef_table_init
    logic [127:0] prod;
    logic [63:0]  step;
    logic [63:0]  series;
    logic [63:0]  term;
    for (int k = 0; k < int'(TABLE_SIZE); k++) begin
      step   = (LN2_FIXED >> EXP_TABLE_BITS) * 64'(k)
             + (((LN2_FIXED & 64'(TABLE_SIZE - 1)) * 64'(k)) >> EXP_TABLE_BITS);
      series = UNITY_Q63;
      term   = UNITY_Q63;
      for (int n = 1; n <= int'(SERIES_TERMS); n++) begin
        prod = 128'(term) * 128'(step);
        term = prod[126:63] / 64'(n);
        if ((n % 2) == 1) begin
          series = series - term;
        end else begin
          series = series + term;
        end
      end
      coef_table[k] = COEF_W'((series + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS));
    end
  end

  // Decay coefficient in Q.FRAC_BITS for the time since the last update.
  // The exponent elapsed * rate / interval is in Q.16; its fraction picks a
  // table entry and its integer part shifts the entry right. An exponent that
  // does not fit in 32 bits, or an integer part of 32 or more, gives zero.
  function automatic logic [COEF_W-1:0] decay_coef(logic [TIME_W-1:0] elapsed);
    logic [68:0]  scaled;
    logic [68:0]  divisor;
    logic [68:0]  expo;
    int unsigned  whole;
    divisor = (cfg_interval == '0) ? 69'd1 : 69'(cfg_interval);
    scaled  = 69'(elapsed) * 69'(cfg_neg_log2);
    if ((scaled >> 32) >= divisor) begin
      return '0;
    end
    expo  = scaled / divisor;
    whole = int'(expo[NEG_LOG2_FRAC +: 16]);
    if (whole >= COEF_SHIFT_LIMIT) begin
      return '0;
    end
    return coef_table[expo[NEG_LOG2_FRAC-1 -: EXP_TABLE_BITS]] >> whole;
  endfunction

  // floor(x * c / 2^FRAC_BITS)
  function automatic logic [63:0] apply_decay(logic [63:0] x, logic [COEF_W-1:0] c);
    logic [127:0] prod;
    prod = 128'(x) * 128'(c);
    return prod[FRAC_BITS +: 64];
  endfunction

  // Moves the averaging state on by one accepted transaction and returns the
  // result the block has to produce for it.
  function automatic tda_result_t advance_average(tda_sample_t item);
    logic [VALUE_W-1:0] value;
    logic [TIME_W-1:0]  elapsed;
    logic [COEF_W-1:0]  coef;
    logic [63:0]        value_fixed;
    logic [63:0]        decayed_ws;
    logic [63:0]        decayed_wt;
    logic [63:0]        quotient;
    logic               restart;
    tda_result_t        res;
    if (item.command == CMD_CLEAR) begin
      // A clear restarts the timing at now_ms; the sample field plays no part.
      avg_last_time    = item.now_ms;
      avg_last_value   = '0;
      avg_weighted_sum = '0;
      avg_weight_sum   = '0;
    end else begin
      value       = (item.sample_ms > SAMPLE_MAX) ? SAMPLE_MAX : item.sample_ms[VALUE_W-1:0];
      value_fixed = 64'(value) << FRAC_BITS;
      restart     = 1'b1;
      if (!cfg_last_only) begin
        elapsed = item.now_ms - avg_last_time;
        coef    = decay_coef(elapsed);
        // A factor of 0.001 or less means the old sums no longer count.
        if (64'(coef) * 64'd1000 > (64'd1 << FRAC_BITS)) begin
          decayed_ws = apply_decay(avg_weighted_sum, coef);
          decayed_wt = apply_decay(64'(avg_weight_sum), coef);
          // Sums that would overflow are restarted as well.
          if (decayed_ws <= WS_MAX - value_fixed &&
              decayed_wt <= 64'(WT_MAX - WEIGHT_UNIT)) begin
            avg_weighted_sum = decayed_ws + value_fixed;
            avg_weight_sum   = WT_W'(decayed_wt) + WEIGHT_UNIT;
            restart          = 1'b0;
          end
        end
      end
      if (restart) begin
        avg_weighted_sum = value_fixed;
        avg_weight_sum   = WEIGHT_UNIT;
      end
      avg_last_value = value;
      avg_last_time  = item.now_ms;
    end

    if (cfg_last_only) begin
      res.average_ms = avg_last_value;
    end else if (avg_weighted_sum == '0 || avg_weight_sum == '0) begin
      res.average_ms = '0;
    end else begin
      quotient       = avg_weighted_sum / 64'(avg_weight_sum);
      res.average_ms = (quotient > 64'(SAMPLE_MAX)) ? SAMPLE_MAX : quotient[VALUE_W-1:0];
    end
    res.last_sample_ms = avg_last_value;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("ERROR: result %0d, %s: got 0x%0h, expected 0x%0h",
             results_checked, what, got, want);
  endtask

  // Sends one transaction on sample_ch. valid stays high after acceptance so
  // that back-to-back transactions follow without a drop of valid; a gap, or the end of
  // a phase, lowers it.
  task automatic send_sample(tda_cmd_e cmd, logic [TIME_W-1:0] now,
                             logic [SAMPLE_IN_W-1:0] sample);
    tda_sample_t item;
    item.command   = cmd;
    item.now_ms    = now;
    item.sample_ms = sample;
    if (tx_gaps_on && burst_left == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= item;
    do @(posedge clk_i); while (!sample_ch.ready);
    expected_results.push_back(advance_average(item));
    items_sent++;
    if (cmd == CMD_CLEAR) begin
      clears_sent++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk_i);
  endtask

  // Stops the sender and waits until every owed result has been taken, so
  // that the block is idle afterwards.
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // One register write. cfg_ch.valid is left high for a following write; the
  // caller lowers it after the last one.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    tda_cfg_t wr;
    wr.reg_index = idx;
    wr.wdata     = data;
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= wr;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_LAST_ONLY: cfg_last_only = data[0];
      CFG_NEG_LOG2:  cfg_neg_log2  = data[NL_W-1:0];
      CFG_INTERVAL:  cfg_interval  = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // Waits for the block to go idle, then writes all three registers. Bits
  // above a register's width are sent as given and must be dropped.
  task automatic configure(logic [CFG_DATA_W-1:0] mode_word, logic [CFG_DATA_W-1:0] rate,
                           logic [CFG_DATA_W-1:0] interval);
    drain_results();
    write_register(CFG_LAST_ONLY, mode_word);
    write_register(CFG_NEG_LOG2, rate);
    write_register(CFG_INTERVAL, interval);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random traffic. Most transactions add a sample a little later than the
  // previous one, with the elapsed time spread over elapsed_bits bits so that
  // the decay exponent covers the table, the shifts and the cutoffs. A few
  // are clears, and a few jump to an arbitrary timestamp, which is usually a
  // step back in time. Samples are mostly of random magnitude, some span all
  // 32 bits, and some use all 40 bits and saturate.
  task automatic run_random_phase(int unsigned count, int unsigned elapsed_bits);
    logic [63:0]            wide;
    logic [SAMPLE_IN_W-1:0] sample;
    int unsigned            pick;
    tda_cmd_e               cmd;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      cmd  = (pick < 5) ? CMD_CLEAR : CMD_ADD;
      if (pick >= 5 && pick < 9) begin
        stream_now = wide[TIME_W-1:0];
      end else begin
        stream_now = stream_now
                   + TIME_W'(wide & ((64'd1 << $urandom_range(0, elapsed_bits)) - 64'd1));
      end
      wide = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        sample = SAMPLE_IN_W'(wide & ((64'd1 << $urandom_range(0, 32)) - 64'd1));
      end else if (pick < 9) begin
        sample = SAMPLE_IN_W'(wide[31:0]);
      end else begin
        sample = wide[SAMPLE_IN_W-1:0];
      end
      send_sample(cmd, stream_now, sample);
    end
  endtask

  // Reset defaults: a rate of one halving per 1000 ms. Covers an empty
  // average, a half-interval step, a decay of nine halvings that still keeps
  // the sums, one of ten halvings that restarts them, an exponent of 32 or more, an
  // exponent that does not fit at all, a step back in time, saturation of the
  // sample, and a clear that carries a sample.
  task automatic test_default_decay();
    send_sample(CMD_ADD, 48'd0, 40'd0);
    send_sample(CMD_ADD, 48'd0, 40'd1000);
    send_sample(CMD_ADD, 48'd500, 40'd2000);
    send_sample(CMD_ADD, 48'd9500, 40'hFF_FFFF_FFFF);
    send_sample(CMD_ADD, 48'd19500, 40'd7);
    send_sample(CMD_ADD, 48'd19501, 40'h00_FFFF_FFFF);
    send_sample(CMD_ADD, 48'd59501, 40'h01_0000_0000);
    send_sample(CMD_ADD, 48'hFFFF_FFFF_FFFF, 40'd123);
    send_sample(CMD_ADD, 48'd5, 40'd456);
    send_sample(CMD_ADD, 48'd3, 40'd789);
    send_sample(CMD_CLEAR, 48'h8000_0000_0000, 40'hAB_CDEF_0123);
    send_sample(CMD_ADD, 48'h8000_0000_0000, 40'h55_5555_5555);
  endtask

  // Register extremes: no decay at all, the largest rate over the longest
  // interval, a zero interval (taken as one) and the finest table step.
  task automatic test_decay_extremes();
    configure(32'd0, 32'd0, 32'd1000);
    send_sample(CMD_ADD, 48'h8000_0000_0064, 40'd10);
    send_sample(CMD_ADD, 48'hFFFF_1234_5678, 40'hAA_AAAA_AAAA);
    configure(32'd0, 32'(NL_W'('1)), 32'hFFFF_FFFF);
    send_sample(CMD_ADD, 48'hFFFF_1234_5679, 40'd20);
    send_sample(CMD_ADD, 48'hFFFF_9234_5679, 40'd30);
    configure(32'd0, 32'(NL_RESET), 32'd0);
    send_sample(CMD_ADD, 48'hFFFF_9234_567A, 40'd100);
    send_sample(CMD_ADD, 48'hFFFF_9234_567A, 40'd200);
    configure(32'd0, 32'd1, 32'd1);
    send_sample(CMD_ADD, 48'hFFFF_9234_577A, 40'd300);
  endtask

  // Last-only mode, entered with a data word whose upper bits are all set,
  // a clear inside it, and a write to the unused register index, which must
  // leave the mode alone. Leaving the mode shows the restarted sums.
  task automatic test_last_only_and_clear();
    configure(32'hFFFF_FFFF, 32'(NL_RESET), 32'(INTERVAL_RESET));
    send_sample(CMD_ADD, 48'd1000, 40'd99);
    send_sample(CMD_ADD, 48'd1005, 40'hFF_FFFF_FFFF);
    send_sample(CMD_CLEAR, 48'd1010, 40'd5);
    drain_results();
    write_register(CFG_UNUSED_IDX, 32'h0000_0000);
    cfg_ch.valid <= 1'b0;
    send_sample(CMD_ADD, 48'd1020, 40'd64);
    configure(32'd0, 32'(NL_RESET), 32'(INTERVAL_RESET));
    send_sample(CMD_ADD, 48'd1520, 40'd128);
    stream_now = 48'd1520;
  endtask

  // Random traffic over several register settings, with and without idling.
  task automatic test_random_traffic();
    configure(32'd0, 32'(NL_RESET), 32'(INTERVAL_RESET));
    run_random_phase(240, 17);

    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    configure(32'd0, 32'd0, $urandom);
    run_random_phase(120, 40);

    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    configure(32'd0, 32'(NL_W'('1)), 32'hFFFF_FFFF);
    run_random_phase(120, 36);

    rx_stalls_on = 1'b0;
    configure(32'd0, 32'd1, 32'd1);
    run_random_phase(120, 22);

    rx_stalls_on = 1'b1;
    configure(32'd0, $urandom_range(1, 4096), 32'd0);
    run_random_phase(100, 12);

    configure($urandom | 32'd1, $urandom, $urandom);
    run_random_phase(120, 30);

    repeat (4) begin
      configure($urandom & ~32'd1, $urandom, $urandom);
      run_random_phase(100, 36);
    end
  endtask

  // The receiver keeps ready at one level for a random number of cycles,
  // high two times in three, unless stalls are switched off.
  always @(negedge clk_i) begin
    if (!rx_stalls_on) begin
      result_ch.ready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end else begin
      result_ch.ready <= ($urandom_range(0, 2) != 0);
      rx_hold = $urandom_range(0, 15);
    end
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", result_ch.payload, '0);
      end else begin
        next_expected = expected_results.pop_front();
        if (result_ch.payload.average_ms != next_expected.average_ms) begin
          report_mismatch("average_ms", 64'(result_ch.payload.average_ms),
                          64'(next_expected.average_ms));
        end
        if (result_ch.payload.last_sample_ms != next_expected.last_sample_ms) begin
          report_mismatch("last_sample_ms", 64'(result_ch.payload.last_sample_ms),
                          64'(next_expected.last_sample_ms));
        end
      end
    end
  end

  // Watchdog for a block that hangs or never answers.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    sample_ch.valid   = 1'b0;
    sample_ch.payload = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.payload    = '0;
    result_ch.ready   = 1'b0;

    // Register defaults and an empty average, as reset leaves the block.
    cfg_last_only    = 1'b0;
    cfg_neg_log2     = NL_RESET;
    cfg_interval     = INTERVAL_RESET;
    avg_last_time    = '0;
    avg_last_value   = '0;
    avg_weighted_sum = '0;
    avg_weight_sum   = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_decay();
    test_decay_extremes();
    test_last_only_and_clear();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Summary: %0d transactions sent (%0d clears), %0d results checked, %0d register writes.",
             items_sent, clears_sent, results_checked, cfg_writes);
    $display("Covered: reset defaults, no decay, extreme rate and interval, zero interval, last-only mode, wrapping time.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
